// ----- design/amb_pkg.sv -----
// shared types, constants and register map of the adaptive mean binarizer
`default_nettype none
package amb_pkg;

	localparam int AMB_MAX_WIDTH  = 1024;
	localparam int AMB_MAX_HEIGHT = 1024;
	localparam int AMB_MAX_RADIUS = 8;

	localparam int AMB_DIM_W  = 11;
	localparam int AMB_RAD_W  = 4;
	localparam int AMB_ADDR_W = 4;
	localparam int AMB_DATA_W = 32;
	localparam int AMB_ROW_W  = 10;
	localparam int AMB_COL_W  = 10;

	localparam logic [AMB_DIM_W-1:0] AMB_RESET_DIM    = 11'd1024;
	localparam logic [AMB_RAD_W-1:0] AMB_RESET_RADIUS = 4'd5;
	localparam logic [7:0]           AMB_WHITE        = 8'd255;
	localparam logic [7:0]           AMB_BLACK        = 8'd0;

	// register indexes, byte address is 4 * index
	localparam logic [1:0] AMB_REG_WIDTH  = 2'd0;
	localparam logic [1:0] AMB_REG_HEIGHT = 2'd1;
	localparam logic [1:0] AMB_REG_RADIUS = 2'd2;

	// input command codes
	localparam logic AMB_CMD_PIXEL = 1'b0;
	localparam logic AMB_CMD_DRAIN = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_SUM,
		ST_CENTER,
		ST_MULT,
		ST_EMIT
	} amb_state_t;

	typedef struct packed {
		logic accept;
		logic start_sum;
		logic read_center;
		logic mult;
		logic emit;
	} amb_cmd_t;

	typedef struct packed {
		logic win_ready;
		logic sum_done;
		logic out_free;
	} amb_sts_t;

endpackage
`default_nettype wire

// ----- design/amb_if.sv -----
// stream channel interfaces for pixel beats and result beats
`default_nettype none
interface amb_pix_if;
	logic       valid;
	logic       ready;
	logic       command;
	logic [7:0] pixel;
	modport source (output valid, output command, output pixel, input ready);
	modport sink (input valid, input command, input pixel, output ready);
endinterface

interface amb_res_if;
	logic       valid;
	logic       ready;
	logic [7:0] bin_value;
	logic [9:0] out_row;
	logic [9:0] out_col;
	logic       frame_last;
	modport source (output valid, output bin_value, output out_row, output out_col,
		output frame_last, input ready);
	modport sink (input valid, input bin_value, input out_row, input out_col,
		input frame_last, output ready);
endinterface
`default_nettype wire

// ----- design/amb_ctrl.sv -----
// sequencing state machine of the binarizer
`default_nettype none
module amb_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  amb_pkg::amb_sts_t sts,
	output amb_pkg::amb_cmd_t cmd
);
	import amb_pkg::*;

	amb_state_t state_q;
	amb_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_CHECK;
			end
			ST_CHECK: begin
				state_d = sts.win_ready ? ST_SUM : ST_IDLE;
			end
			ST_SUM: begin
				if (sts.sum_done) state_d = ST_CENTER;
			end
			ST_CENTER: state_d = ST_MULT;
			ST_MULT:   state_d = ST_EMIT;
			ST_EMIT: begin
				if (sts.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			ST_CHECK:  cmd.start_sum   = sts.win_ready;
			ST_SUM:    cmd             = '0;
			ST_CENTER: cmd.read_center = 1'b1;
			ST_MULT:   cmd.mult        = 1'b1;
			ST_EMIT:   cmd.emit        = sts.out_free;
			default:   cmd             = '0;
		endcase
	end

endmodule
`default_nettype wire

// ----- design/amb_dp.sv -----
// row ring, counters, window accumulator, compare and register file
`default_nettype none
module amb_dp #(
	parameter int MAX_WIDTH  = amb_pkg::AMB_MAX_WIDTH,
	parameter int MAX_HEIGHT = amb_pkg::AMB_MAX_HEIGHT,
	parameter int MAX_RADIUS = amb_pkg::AMB_MAX_RADIUS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  amb_pkg::amb_cmd_t                 cmd,
	output amb_pkg::amb_sts_t                 sts,
	input  logic                              in_command,
	input  logic [7:0]                        in_pixel,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [7:0]                        out_bin_value,
	output logic [amb_pkg::AMB_ROW_W-1:0]     out_row,
	output logic [amb_pkg::AMB_COL_W-1:0]     out_col,
	output logic                              out_frame_last,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [amb_pkg::AMB_ADDR_W-1:0]    paddr,
	input  logic [amb_pkg::AMB_DATA_W-1:0]    pwdata,
	output logic [amb_pkg::AMB_DATA_W-1:0]    prdata
);
	import amb_pkg::*;

	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int HW    = $clog2(MAX_HEIGHT + 1);
	localparam int EW    = $clog2(MAX_HEIGHT);
	localparam int RADW  = $clog2(MAX_RADIUS + 1);
	localparam int RING  = 2 * MAX_RADIUS + 1;
	localparam int RGW   = $clog2(RING);
	localparam int GW    = RGW + 1;
	localparam int AW    = RGW + CW;
	localparam int DEPTH = RING * (2 ** CW);
	localparam int CNTW  = $clog2(4 * MAX_RADIUS * MAX_RADIUS + 1);
	localparam int SUMW  = CNTW + 8;
	localparam int PRODW = CNTW + 9;
	localparam int XW    = ((HW > RADW) ? HW : RADW) + 1;
	localparam int YW    = ((WW > RADW) ? WW : RADW) + 1;

	// configuration registers
	logic [AMB_DIM_W-1:0] cfg_width_q;
	logic [AMB_DIM_W-1:0] cfg_height_q;
	logic [AMB_RAD_W-1:0] cfg_radius_q;
	logic [1:0]           reg_idx;
	logic                 cfg_wr;
	logic                 restart;

	assign reg_idx = paddr[3:2];
	assign cfg_wr  = psel && penable && pwrite;
	assign restart = cfg_wr && (reg_idx == AMB_REG_WIDTH || reg_idx == AMB_REG_HEIGHT ||
		reg_idx == AMB_REG_RADIUS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_width_q  <= AMB_RESET_DIM;
			cfg_height_q <= AMB_RESET_DIM;
			cfg_radius_q <= AMB_RESET_RADIUS;
		end else if (cfg_wr) begin
			case (reg_idx)
				AMB_REG_WIDTH:  cfg_width_q  <= pwdata[AMB_DIM_W-1:0];
				AMB_REG_HEIGHT: cfg_height_q <= pwdata[AMB_DIM_W-1:0];
				AMB_REG_RADIUS: cfg_radius_q <= pwdata[AMB_RAD_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			AMB_REG_WIDTH:  prdata = AMB_DATA_W'(cfg_width_q);
			AMB_REG_HEIGHT: prdata = AMB_DATA_W'(cfg_height_q);
			AMB_REG_RADIUS: prdata = AMB_DATA_W'(cfg_radius_q);
			default:        prdata = '0;
		endcase
	end

	// effective frame size and radius
	logic [WW-1:0]   w_eff;
	logic [HW-1:0]   h_eff;
	logic [RADW-1:0] rad_eff;

	always_comb begin
		if (cfg_width_q == '0) w_eff = WW'(1);
		else if (int'(cfg_width_q) > MAX_WIDTH) w_eff = WW'(MAX_WIDTH);
		else w_eff = WW'(cfg_width_q);
		if (cfg_height_q == '0) h_eff = HW'(1);
		else if (int'(cfg_height_q) > MAX_HEIGHT) h_eff = HW'(MAX_HEIGHT);
		else h_eff = HW'(cfg_height_q);
		if (cfg_radius_q == '0) rad_eff = RADW'(1);
		else if (int'(cfg_radius_q) > MAX_RADIUS) rad_eff = RADW'(MAX_RADIUS);
		else rad_eff = RADW'(cfg_radius_q);
	end

	// position counters
	logic [HW-1:0]  in_row_q;
	logic [CW-1:0]  in_col_q;
	logic [RGW-1:0] in_ring_q;
	logic           complete_q;
	logic [EW-1:0]  emit_row_q;
	logic [CW-1:0]  emit_col_q;
	logic [RGW-1:0] emit_ring_q;
	logic           pix_write;
	logic           frame_end;

	assign pix_write = cmd.accept && (in_command == AMB_CMD_PIXEL) && !complete_q;

	// window bounds of the next result
	logic [XW-1:0]  r1_x;
	logic [XW-1:0]  hm1_x;
	logic [YW-1:0]  c1_y;
	logic [YW-1:0]  wm1_y;
	logic [EW-1:0]  r1;
	logic [CW-1:0]  c1;
	logic [EW-1:0]  r0;
	logic [CW-1:0]  c0;
	logic [GW-1:0]  drow;
	logic [RGW-1:0] ring0;

	always_comb begin
		r1_x  = XW'(emit_row_q) + XW'(rad_eff) - XW'(1);
		hm1_x = XW'(h_eff) - XW'(1);
		r1    = (r1_x > hm1_x) ? EW'(hm1_x) : EW'(r1_x);
		c1_y  = YW'(emit_col_q) + YW'(rad_eff) - YW'(1);
		wm1_y = YW'(w_eff) - YW'(1);
		c1    = (c1_y > wm1_y) ? CW'(wm1_y) : CW'(c1_y);
		if (XW'(emit_row_q) >= XW'(rad_eff)) r0 = EW'(XW'(emit_row_q) - XW'(rad_eff));
		else r0 = '0;
		if (YW'(emit_col_q) >= YW'(rad_eff)) c0 = CW'(YW'(emit_col_q) - YW'(rad_eff));
		else c0 = '0;
		drow = GW'(emit_row_q - r0);
		if (GW'(emit_ring_q) >= drow) ring0 = RGW'(GW'(emit_ring_q) - drow);
		else ring0 = RGW'(GW'(emit_ring_q) + GW'(RING) - drow);
	end

	assign frame_end = (XW'(emit_row_q) == hm1_x) && (YW'(emit_col_q) == wm1_y);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_row_q    <= '0;
			in_col_q    <= '0;
			in_ring_q   <= '0;
			complete_q  <= 1'b0;
			emit_row_q  <= '0;
			emit_col_q  <= '0;
			emit_ring_q <= '0;
		end else if (restart || (cmd.emit && frame_end)) begin
			in_row_q    <= '0;
			in_col_q    <= '0;
			in_ring_q   <= '0;
			complete_q  <= 1'b0;
			emit_row_q  <= '0;
			emit_col_q  <= '0;
			emit_ring_q <= '0;
		end else begin
			if (pix_write) begin
				if (WW'(in_col_q) + WW'(1) >= w_eff) begin
					in_col_q  <= '0;
					in_row_q  <= in_row_q + HW'(1);
					in_ring_q <= (in_ring_q == RGW'(RING - 1)) ? '0 : in_ring_q + RGW'(1);
					if (in_row_q + HW'(1) >= h_eff) complete_q <= 1'b1;
				end else begin
					in_col_q <= in_col_q + CW'(1);
				end
			end
			if (cmd.emit) begin
				if (WW'(emit_col_q) + WW'(1) >= w_eff) begin
					emit_col_q  <= '0;
					emit_row_q  <= emit_row_q + EW'(1);
					emit_ring_q <= (emit_ring_q == RGW'(RING - 1)) ? '0 :
						emit_ring_q + RGW'(1);
				end else begin
					emit_col_q <= emit_col_q + CW'(1);
				end
			end
		end
	end

	assign sts.win_ready = complete_q || (XW'(in_row_q) > XW'(r1)) ||
		((XW'(in_row_q) == XW'(r1)) && (in_col_q > c1));

	// window walk, one ring read per cycle
	logic [EW-1:0]   r_cur_q;
	logic [CW-1:0]   c_cur_q;
	logic [RGW-1:0]  ring_cur_q;
	logic            issuing_q;
	logic            rdv_s1;
	logic [SUMW-1:0] sum_q;
	logic [CNTW-1:0] cnt_q;
	logic [PRODW-1:0] prod_q;
	logic [7:0]      rd_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issuing_q <= 1'b0;
			rdv_s1    <= 1'b0;
		end else if (cmd.start_sum) begin
			issuing_q <= 1'b1;
			rdv_s1    <= 1'b0;
		end else begin
			rdv_s1 <= issuing_q;
			if (issuing_q && (c_cur_q == c1) && (r_cur_q == r1)) issuing_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start_sum) begin
			r_cur_q    <= r0;
			c_cur_q    <= c0;
			ring_cur_q <= ring0;
			sum_q      <= '0;
			cnt_q      <= '0;
		end else begin
			if (issuing_q) begin
				if (c_cur_q == c1) begin
					c_cur_q    <= c0;
					r_cur_q    <= r_cur_q + EW'(1);
					ring_cur_q <= (ring_cur_q == RGW'(RING - 1)) ? '0 :
						ring_cur_q + RGW'(1);
				end else begin
					c_cur_q <= c_cur_q + CW'(1);
				end
			end
			if (rdv_s1) begin
				sum_q <= sum_q + SUMW'(rd_data_q);
				cnt_q <= cnt_q + CNTW'(1);
			end
		end
		if (cmd.mult) prod_q <= PRODW'((9'(rd_data_q) + 9'd1) * PRODW'(cnt_q));
	end

	assign sts.sum_done = !issuing_q && !rdv_s1;

	// row ring memory
	logic [7:0]    ring_mem [DEPTH];
	logic [AW-1:0] rd_addr;

	assign rd_addr = cmd.read_center ? {emit_ring_q, emit_col_q} : {ring_cur_q, c_cur_q};

	always_ff @(posedge clk) begin
		if (pix_write) ring_mem[{in_ring_q, in_col_q}] <= in_pixel;
	end

	always_ff @(posedge clk) begin
		if (issuing_q || cmd.read_center) rd_data_q <= ring_mem[rd_addr];
	end

	// output register
	logic       out_valid_q;
	logic [7:0] out_bin_q;
	logic [AMB_ROW_W-1:0] out_row_q;
	logic [AMB_COL_W-1:0] out_col_q;
	logic       out_last_q;

	assign sts.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			// pixel below floor mean exactly when sum >= (pixel + 1) * count
			out_bin_q  <= (PRODW'(sum_q) >= prod_q) ? AMB_BLACK : AMB_WHITE;
			out_row_q  <= AMB_ROW_W'(emit_row_q);
			out_col_q  <= AMB_COL_W'(emit_col_q);
			out_last_q <= frame_end;
		end
	end

	assign out_valid      = out_valid_q;
	assign out_bin_value  = out_bin_q;
	assign out_row        = out_row_q;
	assign out_col        = out_col_q;
	assign out_frame_last = out_last_q;

`ifndef SYNTHESIS
	a_col_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		WW'(in_col_q) < w_eff)
		else $error("input column outside frame");
	a_bin_levels: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_bin_q == AMB_BLACK || out_bin_q == AMB_WHITE))
		else $error("result not black or white");
	a_window_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mult |-> cnt_q != '0)
		else $error("empty window at compare");
	a_emit_after_sum: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !issuing_q && !rdv_s1)
		else $error("result taken while window walk busy");
`endif

endmodule
`default_nettype wire

// ----- design/adaptive_mean_binarizer_top.sv -----
// adaptive mean binarizer: top level with stream channels and apb register port
// a beat that yields no result goes from check back to idle, where the next beat is accepted
// a beat that yields a result walks a window of N pixels, N the clamped window pixel count
// (up to (2*radius)^2), through the single read port of the row ring, one pixel per cycle
// a finished result waits in the output register while the next beat is taken
// reset clears position counters and output valid, registers go to 1024/1024/5, ring is not cleared
`default_nettype none
module adaptive_mean_binarizer_top #(
	parameter int MAX_WIDTH  = amb_pkg::AMB_MAX_WIDTH,
	parameter int MAX_HEIGHT = amb_pkg::AMB_MAX_HEIGHT,
	parameter int MAX_RADIUS = amb_pkg::AMB_MAX_RADIUS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	amb_pix_if.sink                        pixels,
	amb_res_if.source                      results,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [amb_pkg::AMB_ADDR_W-1:0] paddr,
	input  logic [amb_pkg::AMB_DATA_W-1:0] pwdata,
	output logic [amb_pkg::AMB_DATA_W-1:0] prdata,
	output logic                           pready
);
	import amb_pkg::*;

	// command and status between sequencer and datapath
	amb_cmd_t cmd;
	amb_sts_t sts;

	// register port never stalls
	assign pready = 1'b1;

	// sequencer: idle, check readiness, walk window, read center, multiply, emit
	amb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (pixels.valid),
		.in_ready (pixels.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath: ring memory, counters, accumulator, output register, config registers
	amb_dp #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.MAX_RADIUS (MAX_RADIUS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.in_command     (pixels.command),
		.in_pixel       (pixels.pixel),
		.out_valid      (results.valid),
		.out_ready      (results.ready),
		.out_bin_value  (results.bin_value),
		.out_row        (results.out_row),
		.out_col        (results.out_col),
		.out_frame_last (results.frame_last),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata)
	);

endmodule
`default_nettype wire
